>>> src/ncbc_pkg.sv
// Package of the cache bank tag and miss controller.
// Types, sizes and codes shared by the interfaces, the top level, the checker and the testbench.
package ncbc_pkg;
  localparam int NUM_SETS    = 64;
  localparam int WAY_COUNT   = 4;
  localparam int MISS_DEPTH  = 16;
  localparam int OFS_BITS    = 6;
  localparam int BANK_BITS   = 2;
  localparam int ADDR_W      = 32;
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int WAY_BITS    = $clog2(WAY_COUNT);
  localparam int ENT_BITS    = $clog2(MISS_DEPTH);
  localparam int TAG_LOW     = OFS_BITS + BANK_BITS + SET_BITS;
  localparam int TAG_BITS    = ADDR_W - TAG_LOW;
  localparam int AGE_BITS    = 16;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WB_MODE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_RSP  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BANK_INDEX = 2'd2;

  typedef enum logic [2:0] {
    KIND_CORE_RSP = 3'd0,
    KIND_FILL_RD  = 3'd1,
    KIND_WR_THRU  = 3'd2,
    KIND_WR_BACK  = 3'd3,
    KIND_STALL    = 3'd4
  } kind_t;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
    logic        is_write;
    logic [15:0] req_tag;
    logic [7:0]  core_id;
    logic [3:0]  fill_entry;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] rsp_tag;
    logic [7:0]  rsp_core;
    logic [31:0] mem_address;
    logic [3:0]  mem_entry;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic                valid;
    logic [TAG_BITS-1:0] tag;
    logic                dirty;
    logic [AGE_BITS-1:0] age;
  } line_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [SET_BITS-1:0] set;
    logic [15:0]         req_tag;
    logic [7:0]          core;
    logic                wr;
    logic [WAY_BITS-1:0] way;
  } mshr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT,
    ST_FILL_RD,
    ST_REPLAY
  } state_t;
endpackage

>>> src/ncbc_stream_if.sv
// Valid/ready channels, each carrying one item type.
// Depends on ncbc_pkg for payload types.
interface ncbc_in_if import ncbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ncbc_out_if import ncbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/ncbc_ram.sv
// Generic simple dual-port synchronous RAM (one write, one read port), registered read.
// No dependencies.
module ncbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/nonblocking_cache_bank_controller_top.sv
// Top level of the non-blocking cache bank tag and miss controller.
// Depends on ncbc_pkg, ncbc_in_if/ncbc_out_if and ncbc_ram.
//
// Usage:
//  in  : items of two kinds. func=0 is a core request (address, is_write,
//        req_tag, core_id); func=1 is a memory fill response (fill_entry).
//  out : result items (core response, fill read, write-through, dirty
//        writeback, stall); last marks the final item of an input.
//  cfg : write-back mode, write response enable, bank number; written idle.
// Flow: a core request reads its set (all ways in one wide tag RAM word),
//  decides and writes the set back in the lookup state, then emits up to
//  two items one per cycle while out.ready is high. The next item is taken
//  only after the set read-modify-write and the emission of all results.
//  A fill reads its MSHR entry and set, walks the 16 MSHR entries one per
//  cycle while out.ready is high, emitting a core response per matching
//  entry that answers (writes only with write responses on), then validates
//  its line before the next item is taken. A fill on a free entry is dropped.
// Reset: the clearing pass writes every set of the tag RAM to invalid, age
//  zero, after rst_n rises; no item is accepted meanwhile. MSHR busy bits are
//  flip-flops cleared at once.
// Stall: when the receiver holds out.ready low, the output register holds
//  its item and the sequencer waits; no results are lost.
module nonblocking_cache_bank_controller_top import ncbc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  ncbc_in_if.sink                  in_ch,
  ncbc_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);
  localparam int LINE_W = $bits(line_t);
  localparam int SET_W  = LINE_W * WAY_COUNT;
  localparam int MSHR_W = $bits(mshr_t);

  // configuration
  logic       wb_en_r, write_rsp_r;
  logic [1:0] bank_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_en_r     <= 1'b1;
      write_rsp_r <= 1'b0;
      bank_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WB_MODE:    wb_en_r     <= cfg_data[0];
        CFG_WRITE_RSP:  write_rsp_r <= cfg_data[0];
        CFG_BANK_INDEX: bank_r      <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // storage
  logic                set_we;
  logic [SET_BITS-1:0] set_waddr, set_raddr;
  line_t [WAY_COUNT-1:0] set_wdata, set_rdata;
  logic                mshr_we;
  logic [ENT_BITS-1:0] mshr_waddr, mshr_raddr;
  mshr_t               mshr_wdata, mshr_rdata;

  ncbc_ram #(.WIDTH(SET_W), .DEPTH(NUM_SETS)) u_set_ram (
    .clk(clk), .we(set_we), .waddr(set_waddr), .wdata(set_wdata),
    .raddr(set_raddr), .rdata(set_rdata));
  ncbc_ram #(.WIDTH(MSHR_W), .DEPTH(MISS_DEPTH)) u_mshr_ram (
    .clk(clk), .we(mshr_we), .waddr(mshr_waddr), .wdata(mshr_wdata),
    .raddr(mshr_raddr), .rdata(mshr_rdata));

  logic [MISS_DEPTH-1:0] busy_r, busy_nxt;
  // per-entry line key and write flag copies (flip-flops, fixed reads)
  logic [TAG_BITS+SET_BITS-1:0] key_r [MISS_DEPTH];
  logic [MISS_DEPTH-1:0] wr_q_r;

  // state
  state_t state_r, state_nxt;
  logic   clr_r;
  logic [SET_BITS-1:0] clr_cnt_r;
  in_item_t req_r;
  // queued results for a core request
  out_item_t [2:0] res_r, res_nxt;
  logic [1:0] res_n_r, res_n_nxt, res_i_r, res_i_nxt;
  logic [ENT_BITS:0] walk_r, walk_nxt;
  mshr_t root_q_r;
  logic [TAG_BITS+SET_BITS-1:0] fkey_r;
  logic [4:0] fcnt_r, fcnt_nxt;
  logic fdirty_r, fdirty_nxt;
  logic walk_vld_r;   // mshr_rdata holds entry walk_r-1

  // output register
  out_item_t ob_r, ob_nxt;
  logic ob_v_r, ob_v_nxt;
  logic ob_free;
  assign ob_free = !ob_v_r || out_ch.ready;
  assign out_ch.valid = ob_v_r;
  assign out_ch.data  = ob_r;

  function automatic logic [31:0] maddr(input logic [SET_BITS-1:0] s,
                                        input logic [TAG_BITS-1:0] t,
                                        input logic [1:0] b);
    logic [31:0] a;
    a = '0;
    a[OFS_BITS +: BANK_BITS] = b[BANK_BITS-1:0];
    a[OFS_BITS+BANK_BITS +: SET_BITS] = s;
    a[TAG_LOW +: TAG_BITS] = t;
    return a;
  endfunction

  // request decode
  logic [SET_BITS-1:0] rq_set;
  logic [TAG_BITS-1:0] rq_tag;
  assign rq_set = req_r.address[OFS_BITS+BANK_BITS +: SET_BITS];
  assign rq_tag = req_r.address[TAG_LOW +: TAG_BITS];

  logic full;
  assign full = &busy_r;

  // lookup
  logic hit_f, free_f;
  logic [WAY_BITS-1:0] hit_w, free_w, repl_w, vict_w;
  logic [AGE_BITS-1:0] maxage;
  line_t [WAY_COUNT-1:0] upd;
  logic pending;
  logic [ENT_BITS-1:0] slot;
  always_comb begin
    hit_f = 1'b0; free_f = 1'b0; hit_w = '0; free_w = '0; repl_w = '0;
    maxage = '0; upd = set_rdata;
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (maxage < set_rdata[i].age) begin
        maxage = set_rdata[i].age;
        repl_w = WAY_BITS'(i);
      end
      if (set_rdata[i].valid) begin
        if (set_rdata[i].tag == rq_tag) begin
          hit_f = 1'b1; hit_w = WAY_BITS'(i); upd[i].age = '0;
        end else if (set_rdata[i].age != AGE_MAX) begin
          upd[i].age = set_rdata[i].age + 1'b1;
        end
      end else begin
        free_f = 1'b1; free_w = WAY_BITS'(i);
      end
    end
    vict_w = free_f ? free_w : repl_w;
    pending = 1'b0; slot = '0;
    for (int i = MISS_DEPTH-1; i >= 0; i--) begin
      if (busy_r[i] && key_r[i] == {rq_tag, rq_set}) pending = 1'b1;
      if (!busy_r[i]) slot = ENT_BITS'(i);
    end
  end

  function automatic out_item_t mk(input kind_t k, input logic [15:0] t,
                                   input logic [7:0] c, input logic [31:0] a,
                                   input logic [3:0] e);
    out_item_t o;
    o.kind = k; o.rsp_tag = t; o.rsp_core = c; o.mem_address = a;
    o.mem_entry = e; o.last = 1'b0;
    return o;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (!clr_r && in_ch.valid) begin
          state_nxt = (in_ch.data.func &&
                       !(busy_r[in_ch.data.fill_entry[ENT_BITS-1:0]])) ?
                      ST_IDLE : (in_ch.data.func ? ST_FILL_RD : ST_LOOKUP);
        end
      ST_LOOKUP:  state_nxt = (res_n_nxt == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT:    if (ob_free && res_i_r + 2'd1 == res_n_r) state_nxt = ST_IDLE;
      ST_FILL_RD: state_nxt = ST_REPLAY;
      ST_REPLAY:  if (ob_free && walk_r[ENT_BITS]) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // replay match of the entry now on mshr_rdata
  logic rp_match, rp_emit, rp_last;
  logic [ENT_BITS-1:0] rp_idx;
  assign rp_idx   = ENT_BITS'(walk_r - 1'b1);
  assign rp_match = walk_vld_r && busy_r[rp_idx] &&
                    {mshr_rdata.tag, mshr_rdata.set} == fkey_r;
  assign rp_emit  = rp_match && (!mshr_rdata.wr || write_rsp_r);

  // a response is last when no later entry of the same line answers
  always_comb begin
    rp_last = 1'b1;
    for (int i = 0; i < MISS_DEPTH; i++) begin
      if (ENT_BITS'(i) > rp_idx && busy_r[i] && key_r[i] == fkey_r &&
          (!wr_q_r[i] || write_rsp_r))
        rp_last = 1'b0;
    end
  end

  // outputs / datapath
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE) && !clr_r;
    set_we = 1'b0; set_waddr = rq_set; set_wdata = upd;
    set_raddr = in_ch.data.address[OFS_BITS+BANK_BITS +: SET_BITS];
    mshr_we = 1'b0; mshr_waddr = slot; mshr_raddr = in_ch.data.fill_entry[ENT_BITS-1:0];
    mshr_wdata.tag = rq_tag; mshr_wdata.set = rq_set;
    mshr_wdata.req_tag = req_r.req_tag; mshr_wdata.core = req_r.core_id;
    mshr_wdata.wr = req_r.is_write; mshr_wdata.way = vict_w;
    busy_nxt = busy_r;
    res_nxt = res_r; res_n_nxt = res_n_r; res_i_nxt = res_i_r;
    walk_nxt = walk_r; fcnt_nxt = fcnt_r; fdirty_nxt = fdirty_r;
    ob_nxt = ob_r; ob_v_nxt = ob_v_r && !out_ch.ready;
    if (clr_r) begin
      set_we = 1'b1; set_waddr = clr_cnt_r; set_wdata = '0;
    end
    unique case (state_r)
      ST_IDLE: ;
      ST_LOOKUP: begin
        res_n_nxt = '0; res_i_nxt = '0;
        if ((!req_r.is_write || wb_en_r) && full) begin
          res_nxt[0] = mk(KIND_STALL, req_r.req_tag, req_r.core_id, '0, '0);
          res_n_nxt = 2'd1;
        end else begin
          set_we = 1'b1;
          if (hit_f) begin
            if (req_r.is_write) begin
              if (wb_en_r) set_wdata[hit_w].dirty = 1'b1;
              else begin
                res_nxt[res_n_nxt] = mk(KIND_WR_THRU, '0, req_r.core_id,
                                        maddr(rq_set, rq_tag, bank_r), '0);
                res_n_nxt = res_n_nxt + 2'd1;
              end
            end
            if (!req_r.is_write || write_rsp_r) begin
              res_nxt[res_n_nxt] = mk(KIND_CORE_RSP, req_r.req_tag, req_r.core_id,
                                      '0, '0);
              res_n_nxt = res_n_nxt + 2'd1;
            end
          end else begin
            if (!free_f && wb_en_r && set_rdata[repl_w].dirty) begin
              res_nxt[res_n_nxt] = mk(KIND_WR_BACK, '0, req_r.core_id,
                                      maddr(rq_set, set_rdata[repl_w].tag, bank_r), '0);
              res_n_nxt = res_n_nxt + 2'd1;
            end
            if (req_r.is_write && !wb_en_r) begin
              res_nxt[res_n_nxt] = mk(KIND_WR_THRU, '0, req_r.core_id,
                                      maddr(rq_set, rq_tag, bank_r), '0);
              res_n_nxt = res_n_nxt + 2'd1;
              if (write_rsp_r) begin
                res_nxt[res_n_nxt] = mk(KIND_CORE_RSP, req_r.req_tag,
                                        req_r.core_id, '0, '0);
                res_n_nxt = res_n_nxt + 2'd1;
              end
            end else if (!full) begin
              mshr_we = 1'b1;
              busy_nxt[slot] = 1'b1;
              if (!pending) begin
                res_nxt[res_n_nxt] = mk(KIND_FILL_RD, '0, req_r.core_id,
                                        maddr(rq_set, rq_tag, bank_r), 4'(slot));
                res_n_nxt = res_n_nxt + 2'd1;
              end
            end
          end
        end
      end
      ST_EMIT: if (ob_free) begin
        ob_nxt = res_r[res_i_r];
        ob_nxt.last = (res_i_r + 2'd1 == res_n_r);
        ob_v_nxt = 1'b1;
        res_i_nxt = res_i_r + 2'd1;
      end
      ST_FILL_RD: begin
        // root entry on mshr_rdata; read its set next
        set_raddr = mshr_rdata.set;
        mshr_raddr = '0;
        walk_nxt = '0; fcnt_nxt = '0; fdirty_nxt = 1'b0;
      end
      ST_REPLAY: begin
        set_raddr = root_q_r.set;
        // while stalled, keep the entry on mshr_rdata
        mshr_raddr = (ob_free || !walk_vld_r) ? walk_r[ENT_BITS-1:0] : rp_idx;
        if (ob_free) begin
          if (rp_match && !(rp_emit && fcnt_r == 5'd16)) begin
            busy_nxt[rp_idx] = 1'b0;
            if (mshr_rdata.wr) fdirty_nxt = 1'b1;
            if (rp_emit) begin
              ob_nxt = mk(KIND_CORE_RSP, mshr_rdata.req_tag, mshr_rdata.core, '0, '0);
              ob_nxt.last = rp_last;
              ob_v_nxt = 1'b1;
              fcnt_nxt = fcnt_r + 5'd1;
            end
          end
          if (!walk_r[ENT_BITS]) walk_nxt = walk_r + 1'b1;
          if (walk_r[ENT_BITS]) begin
            // end of walk: write the root line
            set_we = 1'b1; set_waddr = root_q_r.set; set_wdata = set_rdata;
            set_wdata[root_q_r.way].valid = 1'b1;
            set_wdata[root_q_r.way].tag   = root_q_r.tag;
            set_wdata[root_q_r.way].dirty = fdirty_nxt;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; clr_r <= 1'b1; clr_cnt_r <= '0;
      busy_r <= '0; ob_v_r <= 1'b0; res_n_r <= '0; res_i_r <= '0;
      walk_r <= '0; walk_vld_r <= 1'b0; fcnt_r <= '0; fdirty_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == SET_BITS'(NUM_SETS-1)) clr_r <= 1'b0;
      end
      state_r <= state_nxt; busy_r <= busy_nxt; ob_v_r <= ob_v_nxt;
      res_n_r <= res_n_nxt; res_i_r <= res_i_nxt;
      walk_r <= walk_nxt; fcnt_r <= fcnt_nxt; fdirty_r <= fdirty_nxt;
      walk_vld_r <= (state_r == ST_REPLAY && !(ob_free && walk_r[ENT_BITS])) ?
                    (ob_free ? !walk_r[ENT_BITS] : walk_vld_r) : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
    res_r <= res_nxt;
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.data;
    if (state_r == ST_FILL_RD) begin
      root_q_r <= mshr_rdata;
      fkey_r <= {mshr_rdata.tag, mshr_rdata.set};
    end
    if (mshr_we) begin
      key_r[slot] <= {rq_tag, rq_set};
      wr_q_r[slot] <= req_r.is_write;
    end
  end
endmodule

>>> src/ncbc_checker.sv
// Port-level checker for the cache bank controller.
// Depends on ncbc_pkg; bound to the top level.
module ncbc_checker import ncbc_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= KIND_STALL) else $error("kind");
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !in_ready) else $error("ready in clear");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STALL |-> out_data.last) else $error("stall last");
endmodule

bind nonblocking_cache_bank_controller_top ncbc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));

>>> dv/nonblocking_cache_bank_controller_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the cache bank tag and miss controller: drives core requests
// and fill responses, predicts every result and checks them in order.
// Depends on ncbc_pkg, ncbc_in_if/ncbc_out_if and the top level.
module nonblocking_cache_bank_controller_top_tb import ncbc_pkg::*; ();
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  ncbc_in_if in_ch ();
  ncbc_out_if out_ch ();

  nonblocking_cache_bank_controller_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---- predictor state: copy of the tag array and the miss table
  logic [TAG_BITS-1:0] p_tag [NUM_SETS*WAY_COUNT];
  bit p_valid [NUM_SETS*WAY_COUNT];
  bit p_dirty [NUM_SETS*WAY_COUNT];
  logic [15:0] p_age [NUM_SETS*WAY_COUNT];
  bit m_busy [MISS_DEPTH];
  logic [TAG_BITS+SET_BITS-1:0] m_line [MISS_DEPTH];
  logic [15:0] m_rtag [MISS_DEPTH];
  logic [7:0] m_core [MISS_DEPTH];
  bit m_wr [MISS_DEPTH];
  logic [WAY_BITS-1:0] m_way [MISS_DEPTH];
  bit wb_mode = 1'b1;
  bit wr_rsp = 1'b0;
  logic [1:0] bank = 2'd0;

  out_item_t expected_results[$];
  out_item_t step_res[$];
  in_item_t pending_items[$];
  int errors = 0;
  bit tail_part = 1'b0;   // no idling near the end of the run

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [31:0] line_addr(input logic [SET_BITS-1:0] s,
                                            input logic [TAG_BITS-1:0] t);
    return {t, s, bank, {OFS_BITS{1'b0}}};
  endfunction

  function automatic void push_result(input kind_t k, input logic [15:0] rt,
                                      input logic [7:0] c, input logic [31:0] a,
                                      input logic [3:0] e);
    out_item_t r;
    if (step_res.size() >= 16) return;
    r = '{kind: k, rsp_tag: rt, rsp_core: c, mem_address: a, mem_entry: e, last: 1'b0};
    step_res.push_back(r);
  endfunction

  function automatic void apply_fill(input logic [3:0] id);
    logic [TAG_BITS+SET_BITS-1:0] key;
    int li;
    if (!m_busy[id]) return;
    key = m_line[id];
    li = int'(key[SET_BITS-1:0]) * WAY_COUNT + int'(m_way[id]);
    p_valid[li] = 1'b1;
    p_tag[li] = key[TAG_BITS+SET_BITS-1:SET_BITS];
    p_dirty[li] = 1'b0;
    for (int i = 0; i < MISS_DEPTH; i++) begin
      if (!m_busy[i] || m_line[i] != key) continue;
      if (!m_wr[i] || wr_rsp) begin
        if (step_res.size() >= 16) break;
        push_result(KIND_CORE_RSP, m_rtag[i], m_core[i], '0, '0);
      end
      if (m_wr[i]) p_dirty[li] = 1'b1;
      m_busy[i] = 1'b0;
    end
  endfunction

  function automatic void apply_request(input in_item_t it);
    logic [SET_BITS-1:0] s;
    logic [TAG_BITS-1:0] t;
    int busy_cnt, hit, freew, repl, base, slot;
    logic [15:0] maxage;
    bit pend;
    logic [WAY_BITS-1:0] way;
    s = it.address[OFS_BITS+BANK_BITS +: SET_BITS];
    t = it.address[31 -: TAG_BITS];
    busy_cnt = 0; hit = -1; freew = -1; repl = 0; maxage = 0; slot = -1; pend = 0;
    base = int'(s) * WAY_COUNT;
    foreach (m_busy[i]) busy_cnt += m_busy[i];
    if ((!it.is_write || wb_mode) && busy_cnt >= MISS_DEPTH) begin
      push_result(KIND_STALL, it.req_tag, it.core_id, '0, '0);
      return;
    end
    for (int i = 0; i < WAY_COUNT; i++) begin
      if (maxage < p_age[base+i]) begin
        maxage = p_age[base+i];
        repl = i;
      end
      if (p_valid[base+i]) begin
        if (p_tag[base+i] == t) begin
          hit = i;
          p_age[base+i] = 0;
        end else if (p_age[base+i] != AGE_MAX) begin
          p_age[base+i]++;
        end
      end else begin
        freew = i;
      end
    end
    if (hit >= 0) begin
      if (it.is_write) begin
        if (wb_mode) p_dirty[base+hit] = 1'b1;
        else push_result(KIND_WR_THRU, '0, it.core_id, line_addr(s, t), '0);
      end
      if (!it.is_write || wr_rsp) push_result(KIND_CORE_RSP, it.req_tag, it.core_id, '0, '0);
      return;
    end
    if (freew < 0 && wb_mode && p_dirty[base+repl])
      push_result(KIND_WR_BACK, '0, it.core_id, line_addr(s, p_tag[base+repl]), '0);
    if (it.is_write && !wb_mode) begin
      push_result(KIND_WR_THRU, '0, it.core_id, line_addr(s, t), '0);
      if (wr_rsp) push_result(KIND_CORE_RSP, it.req_tag, it.core_id, '0, '0);
      return;
    end
    way = (freew >= 0) ? WAY_BITS'(freew) : WAY_BITS'(repl);
    for (int i = 0; i < MISS_DEPTH; i++) begin
      if (m_busy[i] && m_line[i] == {t, s}) pend = 1'b1;
      if (!m_busy[i] && slot < 0) slot = i;
    end
    if (slot < 0) return;
    m_busy[slot] = 1'b1;
    m_line[slot] = {t, s};
    m_rtag[slot] = it.req_tag;
    m_core[slot] = it.core_id;
    m_wr[slot] = it.is_write;
    m_way[slot] = way;
    if (!pend) push_result(KIND_FILL_RD, '0, it.core_id, line_addr(s, t), 4'(slot));
  endfunction

  // Runs the predictor on one accepted item and queues its results.
  function automatic void predict_item(input in_item_t it);
    step_res.delete();
    if (it.func) apply_fill(it.fill_entry);
    else apply_request(it);
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) expected_results.push_back(step_res[i]);
  endfunction

  // ---- driver: feeds pending_items, random idle bursts
  int in_gap = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_item(in_ch.data);
      if (in_ch.valid && !in_ch.ready) begin
        // hold the item until it is taken
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!tail_part && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 13) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.data <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---- monitor: checks results, random stall bursts on ready
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.rsp_tag !== want.rsp_tag ||
              got.rsp_core !== want.rsp_core || got.mem_address !== want.mem_address ||
              got.mem_entry !== want.mem_entry || got.last !== want.last)
            report_mismatch($sformatf("got %p want %p", got, want));
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!tail_part && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 13) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---- watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 3000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---- stimulus helpers
  function automatic in_item_t req_item(input logic [31:0] a, input bit w);
    in_item_t it;
    it = '0;
    it.address = a;
    it.is_write = w;
    it.req_tag = 16'($urandom);
    it.core_id = 8'($urandom);
    it.fill_entry = 4'($urandom);
    return it;
  endfunction

  function automatic in_item_t fill_rsp(input logic [3:0] e);
    in_item_t it;
    it = '0;
    it.func = 1'b1;
    it.fill_entry = e;
    it.address = $urandom;   // ignored by a fill
    it.req_tag = 16'($urandom);
    return it;
  endfunction

  // Address from a small pool so that sets and lines collide often.
  function automatic logic [31:0] pool_addr();
    logic [31:0] a;
    a = $urandom;
    a[OFS_BITS+BANK_BITS +: SET_BITS] = SET_BITS'($urandom_range(0, 3));
    a[31 -: TAG_BITS] = TAG_BITS'($urandom_range(0, 7)) ^ {TAG_BITS{a[0] & a[1] & a[2]}};
    return a;
  endfunction

  task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic [1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WB_MODE:   wb_mode = v[0];
      CFG_WRITE_RSP: wr_rsp = v[0];
      default:       bank = v;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);   // fill walks may still be running
  endtask

  // Random phase: requests mixed with fills on busy entries, some noise.
  task automatic random_phase(input int count);
    logic [3:0] e;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pending_items.push_back(req_item(pool_addr(), $urandom_range(0, 1)));
        5:             pending_items.push_back(req_item($urandom, $urandom_range(0, 1)));
        6, 7, 8: begin
          e = 4'($urandom);
          // predictor is behind the queue; a stale entry just gives an ignored fill
          for (int k = 0; k < MISS_DEPTH; k++)
            if (m_busy[(int'(e) + k) % MISS_DEPTH]) begin
              e = 4'((int'(e) + k) % MISS_DEPTH);
              break;
            end
          pending_items.push_back(fill_rsp(e));
        end
        default:       pending_items.push_back(fill_rsp(4'($urandom)));
      endcase
      if (pending_items.size() > 4) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    foreach (p_valid[i]) begin
      p_valid[i] = 0; p_dirty[i] = 0; p_age[i] = '0; p_tag[i] = '0;
    end
    foreach (m_busy[i]) m_busy[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    repeat (NUM_SETS + 4) @(posedge clk);

    // Directed: fill on a free entry, address extremes, write hit, secondary miss,
    // full miss table with stall.
    pending_items.push_back(fill_rsp(4'd15));
    pending_items.push_back(req_item(32'h0000_0000, 1'b0));
    pending_items.push_back(req_item(32'hFFFF_FFFF, 1'b1));
    pending_items.push_back(req_item(32'h0000_0004, 1'b0));   // same line, no new fill read
    pending_items.push_back(fill_rsp(4'd0));
    pending_items.push_back(fill_rsp(4'd1));
    pending_items.push_back(req_item(32'h0000_0000, 1'b1));   // write hit
    for (int w = 1; w <= 4; w++)
      pending_items.push_back(req_item({20'(w), 12'h000}, 1'b0));
    for (int k = 0; k < 12; k++)
      pending_items.push_back(req_item({20'(k + 40), 6'(k), 6'h0}, 1'b0));
    pending_items.push_back(req_item(32'h1234_5678, 1'b0));   // miss table full
    pending_items.push_back(req_item(32'h1234_5678, 1'b1));
    drain();
    for (int e = 0; e < MISS_DEPTH; e++) pending_items.push_back(fill_rsp(4'(e)));
    drain();

    write_cfg(CFG_WRITE_RSP, 2'd1);
    write_cfg(CFG_BANK_INDEX, 2'd3);
    random_phase(110);
    write_cfg(CFG_WB_MODE, 2'd0);
    random_phase(100);
    write_cfg(CFG_WRITE_RSP, 2'd0);
    write_cfg(CFG_BANK_INDEX, 2'd1);
    random_phase(100);
    write_cfg(CFG_WB_MODE, 2'd1);
    write_cfg(CFG_BANK_INDEX, 2'd2);
    tail_part = 1'b1;
    random_phase(80);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
